/* sv/eps_pkg.sv */
// Shared types, constants and series tables for the equirectangular to sphere point block.
package eps_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 24;

  localparam int ELEV_W = 16;
  localparam int RAD_W  = 24;
  localparam int SUM_W  = 26;
  localparam int OUT_W  = 34;
  localparam int CFG_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 2'd2;

  localparam int MAP_WIDTH_RST     = 4096;
  localparam int MAP_HEIGHT_RST    = 2048;
  localparam int SPHERE_RADIUS_RST = 6371;

  // Q30 fixed point: unsigned magnitudes up to and including one.
  localparam int Q30_W = 31;
  localparam int TRIG_W = 32;
  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [Q30_W-1:0] HALF_PI_Q30 = 31'd1686629713;

  // Register stages of one quarter-wave sine unit.
  localparam int QSINE_LAT = 25;
  localparam int SERIES_TERMS = 7;

  typedef struct packed {
    logic signed [SUM_W-1:0] radius;
    logic                    water;
  } eps_side_t;

  // Series term j uses k = 7 - j; the divisor is 2k(2k+1).
  function automatic logic [7:0] series_den(input int j);
    logic [7:0] d;
    unique case (j)
      0: d = 8'd210;
      1: d = 8'd156;
      2: d = 8'd110;
      3: d = 8'd72;
      4: d = 8'd42;
      5: d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^shift / divisor); the estimate it gives is low by at most one.
  function automatic logic [32:0] series_recip(input int j);
    logic [32:0] m;
    unique case (j)
      0: m = 33'd5235769656;
      1: m = 33'd7048151460;
      2: m = 33'd4997780126;
      3: m = 33'd7635497415;
      4: m = 33'd6544712070;
      5: m = 33'd6871947673;
      default: m = 33'd5726623061;
    endcase
    return m;
  endfunction

  function automatic int series_shift(input int j);
    int s;
    unique case (j)
      0: s = 40;
      1: s = 40;
      2: s = 39;
      3: s = 39;
      4: s = 38;
      5: s = 37;
      default: s = 35;
    endcase
    return s;
  endfunction

endpackage

/* sv/eps_div.sv */
// Pipelined restoring divider producing one quotient bit per stage.
module eps_div
  import eps_pkg::*;
#(
  parameter int NUM_W = PIXEL_BITS_DEF,
  parameter int SHIFT = ANGLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output logic [SHIFT:0]   quo
);

  localparam int STAGES = NUM_W + SHIFT;
  localparam int QW = SHIFT + 1;

  logic [NUM_W-1:0] rem_s [STAGES+1];
  logic [NUM_W-1:0] num_s [STAGES+1];
  logic [QW-1:0]    quo_s [STAGES+1];

  assign rem_s[0] = '0;
  assign num_s[0] = num;
  assign quo_s[0] = '0;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [NUM_W:0]   trial;
    logic [NUM_W:0]   diff;
    logic             ge;
    logic [NUM_W-1:0] rem_r;
    logic [NUM_W-1:0] num_r;
    logic [QW-1:0]    quo_r;

    assign trial = {rem_s[i], num_s[i][NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
        num_r <= {num_s[i][NUM_W-2:0], 1'b0};
        quo_r <= {quo_s[i][QW-2:0], ge};
      end
    end

    assign rem_s[i+1] = rem_r;
    assign num_s[i+1] = num_r;
    assign quo_s[i+1] = quo_r;
  end

  assign quo = quo_s[STAGES];

endmodule

/* sv/eps_qsine.sv */
// Pipelined quarter-wave sine in Q30 using a nested odd-power series.
module eps_qsine
  import eps_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [Q30_W-1:0] p,
  output logic [Q30_W-1:0] s
);

  logic [61:0]      px_prod;
  logic [Q30_W-1:0] x0;
  logic [61:0]      xx_prod;
  logic [Q30_W-1:0] x1;
  logic [31:0]      x2_0;

  assign px_prod = p * HALF_PI_Q30;
  assign xx_prod = x0 * x0;

  always_ff @(posedge clk) begin
    if (en) begin
      x0   <= px_prod[60:30];
      x1   <= x0;
      x2_0 <= xx_prod[61:30];
    end
  end

  logic [Q30_W-1:0] it_x  [SERIES_TERMS+1];
  logic [31:0]      it_x2 [SERIES_TERMS+1];
  logic [Q30_W-1:0] it_t  [SERIES_TERMS+1];

  assign it_x[0]  = x1;
  assign it_x2[0] = x2_0;
  assign it_t[0]  = Q30_ONE;

  // Each term takes three stages: product, reciprocal estimate, correction.
  for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
    localparam logic [31:0] DEN   = 32'(series_den(j));
    localparam logic [32:0] RECIP = series_recip(j);
    localparam int          SH    = series_shift(j);

    logic [62:0]      mul_a;
    logic [31:0]      a_v;
    logic [Q30_W-1:0] a_x;
    logic [31:0]      a_x2;
    logic [64:0]      mul_b;
    logic [64:0]      sh_b;
    logic [31:0]      b_q;
    logic [31:0]      b_v;
    logic [Q30_W-1:0] b_x;
    logic [31:0]      b_x2;
    logic [31:0]      rem_c;
    logic [31:0]      q_c;
    logic [Q30_W-1:0] c_t;
    logic [Q30_W-1:0] c_x;
    logic [31:0]      c_x2;

    assign mul_a = it_x2[j] * it_t[j];
    assign mul_b = a_v * RECIP;
    assign sh_b  = mul_b >> SH;
    assign rem_c = b_v - b_q * DEN;
    assign q_c   = (rem_c >= DEN) ? b_q + 32'd1 : b_q;

    always_ff @(posedge clk) begin
      if (en) begin
        a_v  <= mul_a[61:30];
        a_x  <= it_x[j];
        a_x2 <= it_x2[j];
        b_q  <= sh_b[31:0];
        b_v  <= a_v;
        b_x  <= a_x;
        b_x2 <= a_x2;
        c_t  <= Q30_ONE - q_c[Q30_W-1:0];
        c_x  <= b_x;
        c_x2 <= b_x2;
      end
    end

    assign it_x[j+1]  = c_x;
    assign it_x2[j+1] = c_x2;
    assign it_t[j+1]  = c_t;
  end

  logic [61:0]      mul_f;
  logic [31:0]      f_s;
  logic [Q30_W-1:0] s_r;

  assign mul_f = it_x[SERIES_TERMS] * it_t[SERIES_TERMS];

  always_ff @(posedge clk) begin
    if (en) begin
      f_s <= mul_f[61:30];
      s_r <= (f_s > {1'b0, Q30_ONE}) ? Q30_ONE : f_s[Q30_W-1:0];
    end
  end

  assign s = s_r;

endmodule

/* sv/eps_front.sv */
// Input side: takes items, forms radius and water flag, and queues them for the datapath.
module eps_front
  import eps_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIXEL_BITS-1:0]   pixel_col,
  input  logic [PIXEL_BITS-1:0]   pixel_row,
  input  logic signed [ELEV_W-1:0] elevation,
  input  logic [RAD_W-1:0]        sphere_radius,
  input  logic                    pop,
  output logic                    q_valid,
  output logic [PIXEL_BITS-1:0]   q_col,
  output logic [PIXEL_BITS-1:0]   q_row,
  output eps_side_t               q_side
);

  logic [PIXEL_BITS-1:0] col_q  [2];
  logic [PIXEL_BITS-1:0] row_q  [2];
  eps_side_t             side_q [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  push;
  logic                  take;
  eps_side_t             side_in;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign take     = pop && q_valid;

  assign side_in.radius = $signed({2'b00, sphere_radius}) +
                          SUM_W'(elevation);
  assign side_in.water  = (elevation <= 0);

  always_ff @(posedge clk) begin
    if (push) begin
      col_q[wr_ptr]  <= pixel_col;
      row_q[wr_ptr]  <= pixel_row;
      side_q[wr_ptr] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end

  assign q_col  = col_q[rd_ptr];
  assign q_row  = row_q[rd_ptr];
  assign q_side = side_q[rd_ptr];

endmodule

/* sv/eps_back.sv */
// Datapath: angle division, sine and cosine, products and rounding, and the output register.
module eps_back
  import eps_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  logic [PIXEL_BITS-1:0]   q_col,
  input  logic [PIXEL_BITS-1:0]   q_row,
  input  eps_side_t               q_side,
  output logic                    pop,
  input  logic [PIXEL_BITS-1:0]   map_width,
  input  logic [PIXEL_BITS-1:0]   map_height,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] point_x,
  output logic signed [OUT_W-1:0] point_y,
  output logic signed [OUT_W-1:0] point_z,
  output logic                    is_water
);

  localparam int DIV_LAT = PIXEL_BITS + ANGLE_BITS;
  localparam int LAT = DIV_LAT + QSINE_LAT + 6;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  logic en;
  assign en  = !out_valid || out_ready;
  assign pop = en;

  // Valid bits and sideband travel with the datapath; everything moves on en.
  logic [LAT-1:0] vld;
  eps_side_t      side_d [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= q_side;
      for (int i = 1; i < LAT; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  logic [PIXEL_BITS-1:0] den_w;
  logic [PIXEL_BITS-1:0] den_h;
  logic [ANGLE_BITS:0]   quo_lng;
  logic [ANGLE_BITS:0]   quo_lat;

  // A zero size register acts as one.
  assign den_w = (map_width == '0) ? PIXEL_BITS'(1) : map_width;
  assign den_h = (map_height == '0) ? PIXEL_BITS'(1) : map_height;

  eps_div #(.NUM_W(PIXEL_BITS), .SHIFT(ANGLE_BITS)) u_div_lng (
    .clk (clk),
    .en  (en),
    .num (q_col),
    .den (den_w),
    .quo (quo_lng)
  );

  eps_div #(.NUM_W(PIXEL_BITS), .SHIFT(ANGLE_BITS)) u_div_lat (
    .clk (clk),
    .en  (en),
    .num (q_row),
    .den (den_h),
    .quo (quo_lat)
  );

  // Latitude uses half the scale, so the quotient drops its lowest bit.
  logic [ANGLE_BITS-1:0] lng_a;
  logic [ANGLE_BITS-1:0] lat_a;
  logic [31:0]           ph_lng;
  logic [31:0]           ph_lat;
  logic [Q30_W-1:0]      p_lng;
  logic [Q30_W-1:0]      pc_lng;
  logic [Q30_W-1:0]      p_lat;
  logic [Q30_W-1:0]      pc_lat;
  logic [1:0]            quad_lng [QSINE_LAT+1];
  logic [1:0]            quad_lat [QSINE_LAT+1];

  assign lng_a  = HALF_TURN - quo_lng[ANGLE_BITS-1:0];
  assign lat_a  = QUARTER_TURN - quo_lat[ANGLE_BITS:1];
  assign ph_lng = 32'(lng_a) << (32 - ANGLE_BITS);
  assign ph_lat = 32'(lat_a) << (32 - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      p_lng       <= {1'b0, ph_lng[29:0]};
      pc_lng      <= Q30_ONE - {1'b0, ph_lng[29:0]};
      p_lat       <= {1'b0, ph_lat[29:0]};
      pc_lat      <= Q30_ONE - {1'b0, ph_lat[29:0]};
      quad_lng[0] <= ph_lng[31:30];
      quad_lat[0] <= ph_lat[31:30];
      for (int i = 1; i <= QSINE_LAT; i++) begin
        quad_lng[i] <= quad_lng[i-1];
        quad_lat[i] <= quad_lat[i-1];
      end
    end
  end

  logic [Q30_W-1:0] sa_lng;
  logic [Q30_W-1:0] sb_lng;
  logic [Q30_W-1:0] sa_lat;
  logic [Q30_W-1:0] sb_lat;

  eps_qsine u_sa_lng (.clk(clk), .en(en), .p(p_lng),  .s(sa_lng));
  eps_qsine u_sb_lng (.clk(clk), .en(en), .p(pc_lng), .s(sb_lng));
  eps_qsine u_sa_lat (.clk(clk), .en(en), .p(p_lat),  .s(sa_lat));
  eps_qsine u_sb_lat (.clk(clk), .en(en), .p(pc_lat), .s(sb_lat));

  logic signed [TRIG_W-1:0] slng;
  logic signed [TRIG_W-1:0] clng;
  logic signed [TRIG_W-1:0] slat;
  logic signed [TRIG_W-1:0] clat;
  logic signed [TRIG_W-1:0] slng_n;
  logic signed [TRIG_W-1:0] clng_n;
  logic signed [TRIG_W-1:0] slat_n;
  logic signed [TRIG_W-1:0] clat_n;
  logic signed [TRIG_W-1:0] al;
  logic signed [TRIG_W-1:0] bl;
  logic signed [TRIG_W-1:0] at;
  logic signed [TRIG_W-1:0] bt;

  // Quadrant symmetry turns the two quarter-wave values into sine and cosine.
  always_comb begin
    al = $signed({1'b0, sa_lng});
    bl = $signed({1'b0, sb_lng});
    at = $signed({1'b0, sa_lat});
    bt = $signed({1'b0, sb_lat});
    unique case (quad_lng[QSINE_LAT])
      2'd0: begin slng_n = al;  clng_n = bl;  end
      2'd1: begin slng_n = bl;  clng_n = -al; end
      2'd2: begin slng_n = -al; clng_n = -bl; end
      default: begin slng_n = -bl; clng_n = al; end
    endcase
    unique case (quad_lat[QSINE_LAT])
      2'd0: begin slat_n = at;  clat_n = bt;  end
      2'd1: begin slat_n = bt;  clat_n = -at; end
      2'd2: begin slat_n = -at; clat_n = -bt; end
      default: begin slat_n = -bt; clat_n = at; end
    endcase
  end

  function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + ((v < 0) ? 64'sd536870911 : 64'sd536870912);
    return t[61:30];
  endfunction

  function automatic logic signed [OUT_W-1:0] rnd22(input logic signed [57:0] v);
    logic signed [57:0] t;
    t = v + ((v < 0) ? 58'sd2097151 : 58'sd2097152);
    return t[55:22];
  endfunction

  logic signed [63:0]       pfx;
  logic signed [63:0]       pfy;
  logic signed [TRIG_W-1:0] slat_p;
  logic signed [TRIG_W-1:0] fx;
  logic signed [TRIG_W-1:0] fy;
  logic signed [TRIG_W-1:0] fz;
  logic signed [57:0]       mx;
  logic signed [57:0]       my;
  logic signed [57:0]       mz;
  logic signed [SUM_W-1:0]  rad;

  assign rad = side_d[LAT-3].radius;

  always_ff @(posedge clk) begin
    if (en) begin
      slng    <= slng_n;
      clng    <= clng_n;
      slat    <= slat_n;
      clat    <= clat_n;
      pfx     <= clat * clng;
      pfy     <= clat * slng;
      slat_p  <= slat;
      fx      <= rnd30(pfx);
      fy      <= rnd30(pfy);
      fz      <= slat_p;
      mx      <= rad * fx;
      my      <= rad * fy;
      mz      <= rad * fz;
      point_x <= rnd22(mx);
      point_y <= rnd22(my);
      point_z <= rnd22(mz);
    end
  end

  assign out_valid = vld[LAT-1];
  assign is_water  = side_d[LAT-1].water;

endmodule

/* sv/equirect_pixel_to_sphere_point.sv */
// Top level: maps a height-map sample to a Cartesian point on a sphere.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_ready   | pixel_col, pixel_row, elevation
//   out     | out_valid / out_ready | point_x, point_y, point_z, is_water
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle is sustained while the output is not stalled. The angle dividers
// resolve one quotient bit per stage, and the sine units spend three stages on each of the
// seven series terms.
// Reset clears the queue and valid bits and restores the config defaults; no clearing pass.
// A stalled output freezes the whole datapath, and the two-entry queue drops in_ready.
module equirect_pixel_to_sphere_point
  import eps_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIXEL_BITS-1:0]   pixel_col,
  input  logic [PIXEL_BITS-1:0]   pixel_row,
  input  logic signed [ELEV_W-1:0] elevation,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] point_x,
  output logic signed [OUT_W-1:0] point_y,
  output logic signed [OUT_W-1:0] point_z,
  output logic                    is_water,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int LAT = PIXEL_BITS + ANGLE_BITS + QSINE_LAT + 6;
  localparam int CNT_W = $clog2(LAT + 4);

  logic [PIXEL_BITS-1:0] map_width;
  logic [PIXEL_BITS-1:0] map_height;
  logic [RAD_W-1:0]      sphere_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= PIXEL_BITS'(MAP_WIDTH_RST);
      map_height    <= PIXEL_BITS'(MAP_HEIGHT_RST);
      sphere_radius <= RAD_W'(SPHERE_RADIUS_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:     map_width     <= cfg_data[PIXEL_BITS-1:0];
        CFG_MAP_HEIGHT:    map_height    <= cfg_data[PIXEL_BITS-1:0];
        CFG_SPHERE_RADIUS: sphere_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic                  pop;
  logic                  q_valid;
  logic [PIXEL_BITS-1:0] q_col;
  logic [PIXEL_BITS-1:0] q_row;
  eps_side_t             q_side;

  eps_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .elevation     (elevation),
    .sphere_radius (sphere_radius),
    .pop           (pop),
    .q_valid       (q_valid),
    .q_col         (q_col),
    .q_row         (q_row),
    .q_side        (q_side)
  );

  eps_back #(.PIXEL_BITS(PIXEL_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_col      (q_col),
    .q_row      (q_row),
    .q_side     (q_side),
    .pop        (pop),
    .map_width  (map_width),
    .map_height (map_height),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .is_water   (is_water)
  );

  // Items accepted but not yet delivered.
  logic [CNT_W-1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);
    end
  end

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result presented with no item in flight");

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(LAT + 2))
    else $error("more items in flight than the datapath and queue can hold");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input held off without an output stall");

endmodule

/* bench/tb.sv */
// Testbench for the equirectangular pixel to sphere point block.
`timescale 1ns / 100ps

module tb;
  import eps_pkg::*;

  localparam int PB = 16;
  localparam int AB = 24;
  localparam int LATENCY = PB + AB + 40;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    water;
  } point_t;

  typedef struct {
    logic [PB-1:0]     col;
    logic [PB-1:0]     row;
    logic [ELEV_W-1:0] elev;
    bit                typed;
    point_t            pt;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PB-1:0] pixel_col = '0;
  logic [PB-1:0] pixel_row = '0;
  logic signed [ELEV_W-1:0] elevation = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] point_x, point_y, point_z;
  logic is_water;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Mirror of the block's registers.
  longint unsigned width_reg, height_reg, radius_reg;
  point_t pending_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  equirect_pixel_to_sphere_point u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_col(pixel_col), .pixel_row(pixel_row), .elevation(elevation),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z), .is_water(is_water),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint unsigned quarter_wave(longint unsigned p);
    longint unsigned x, x2, t, s;
    x = (p * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int k = 7; k >= 1; k--)
      t = (64'd1 << 30) - ((x2 * t) >> 30) / ((2 * k) * (2 * k + 1));
    s = (x * t) >> 30;
    return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
  endfunction

  // Returns sine and cosine in signed Q30 of an angle in turns.
  function automatic void angle_trig(input longint unsigned ang, output longint sn,
                                     output longint cs);
    longint unsigned phase, p;
    longint a, b;
    phase = (ang << (32 - AB)) & 64'hFFFF_FFFF;
    p = phase & ((64'd1 << 30) - 1);
    a = longint'(quarter_wave(p));
    b = longint'(quarter_wave((64'd1 << 30) - p));
    case (phase >> 30)
      0: begin sn = a; cs = b; end
      1: begin sn = b; cs = -a; end
      2: begin sn = -a; cs = -b; end
      default: begin sn = -b; cs = a; end
    endcase
  endfunction

  function automatic longint scaled_round(longint a, longint b, int sh);
    longint unsigned ma, mb, m;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic point_t sphere_point(logic [PB-1:0] col, logic [PB-1:0] row,
                                          logic signed [ELEV_W-1:0] elev);
    longint unsigned w, h, lng, lat, amask;
    longint slng, clng, slat, clat, r, fx, fy;
    point_t pt;
    amask = (64'd1 << AB) - 1;
    w = (width_reg == 0) ? 1 : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    lng = ((64'd1 << (AB - 1)) - ((longint'(col) << AB) / w)) & amask;
    lat = ((64'd1 << (AB - 2)) - ((longint'(row) << (AB - 1)) / h)) & amask;
    angle_trig(lng, slng, clng);
    angle_trig(lat, slat, clat);
    fx = scaled_round(clat, clng, 30);
    fy = scaled_round(clat, slng, 30);
    r = longint'(radius_reg) + longint'(elev);
    pt.x = OUT_W'(scaled_round(r, fx, 22));
    pt.y = OUT_W'(scaled_round(r, fy, 22));
    pt.z = OUT_W'(scaled_round(r, slat, 22));
    pt.water = (elev <= 0);
    return pt;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAP_WIDTH: width_reg = val & 16'hFFFF;
      CFG_MAP_HEIGHT: height_reg = val & 16'hFFFF;
      CFG_SPHERE_RADIUS: radius_reg = val & 24'hFF_FFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Valid stays high between back-to-back items; it drops only while idling.
  task automatic send_sample(logic [PB-1:0] col, logic [PB-1:0] row,
                             logic [ELEV_W-1:0] elev, bit typed, point_t pt);
    point_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    elevation <= elev;
    expected = sphere_point(col, row, elev);
    if (typed && expected !== pt) begin
      $error("typed row disagrees with predictor for col %0d row %0d", col, row);
      errors++;
    end
    pending_points.push_back(typed ? pt : expected);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_points.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic random_samples(int n, int wmax, int hmax);
    logic [PB-1:0] c, r;
    point_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      // Mostly indices inside the map, sometimes anywhere.
      if ($urandom_range(9) < 8 && wmax > 0) begin
        c = PB'($urandom_range(wmax - 1));
        r = PB'($urandom_range(hmax - 1));
      end else begin
        c = PB'($urandom);
        r = PB'($urandom);
      end
      send_sample(c, r, ELEV_W'($urandom), 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          $error("unexpected item: x %0d y %0d z %0d", point_x, point_y, point_z);
          errors++;
        end else begin
          want = pending_points.pop_front();
          if (point_x !== want.x) begin
            $error("point_x expected %0d actual %0d", want.x, point_x); errors++;
          end
          if (point_y !== want.y) begin
            $error("point_y expected %0d actual %0d", want.y, point_y); errors++;
          end
          if (point_z !== want.z) begin
            $error("point_z expected %0d actual %0d", want.z, point_z); errors++;
          end
          if (is_water !== want.water) begin
            $error("is_water expected %0d actual %0d", want.water, is_water); errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Default map: col 2048 is longitude 0, row 1024 the equator, row 0 the north pole.
  sample_row_t directed[13] = '{
    '{16'd2048, 16'd1024, 16'd0,      1'b1, '{34'sd1630976, 34'sd0, 34'sd0, 1'b1}},
    '{16'd2048, 16'd1024, 16'd1,      1'b1, '{34'sd1631232, 34'sd0, 34'sd0, 1'b0}},
    '{16'd2048, 16'd0,    16'd0,      1'b1, '{34'sd0, 34'sd0, 34'sd1630976, 1'b1}},
    '{16'd0,    16'd0,    16'h7FFF,   1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'h8000,   1'b0, '0},
    '{16'd0,    16'hFFFF, 16'hFFFF,   1'b0, '0},
    '{16'hFFFF, 16'd0,    16'h0001,   1'b0, '0},
    '{16'd1024, 16'd2048, 16'd100,    1'b0, '0},
    '{16'd3072, 16'd512,  16'hFF9C,   1'b0, '0},
    '{16'd4096, 16'd4096, 16'd0,      1'b0, '0},
    '{16'd8191, 16'd3000, 16'd5000,   1'b0, '0},
    '{16'h5555, 16'hAAAA, 16'h5555,   1'b0, '0},
    '{16'hAAAA, 16'h5555, 16'hAAAA,   1'b0, '0}
  };

  initial begin
    point_t none;
    none = '0;
    width_reg = MAP_WIDTH_RST;
    height_reg = MAP_HEIGHT_RST;
    radius_reg = SPHERE_RADIUS_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_sample(directed[i].col, directed[i].row, directed[i].elev,
                  directed[i].typed, directed[i].pt);
    // Wait for every result before touching the registers.
    drain();

    // Extreme settings, with zero width and height treated as one.
    write_reg(CFG_MAP_WIDTH, 0);
    write_reg(CFG_MAP_HEIGHT, 0);
    write_reg(CFG_SPHERE_RADIUS, 0);
    for (int i = 0; i < 12; i++)
      send_sample(PB'($urandom), PB'($urandom), ELEV_W'($urandom), 1'b0, none);
    drain();
    write_reg(CFG_MAP_WIDTH, 16'hFFFF);
    write_reg(CFG_MAP_HEIGHT, 16'hFFFF);
    write_reg(CFG_SPHERE_RADIUS, 24'hFF_FFFF);
    send_sample(16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b0, none);
    send_sample(16'd0, 16'd0, 16'h8000, 1'b0, none);
    random_samples(80, 65535, 65535);
    drain();

    write_reg(CFG_MAP_WIDTH, 1);
    write_reg(CFG_MAP_HEIGHT, 1);
    write_reg(CFG_SPHERE_RADIUS, 1);
    random_samples(40, 1, 1);
    drain();

    write_reg(CFG_MAP_WIDTH, MAP_WIDTH_RST);
    write_reg(CFG_MAP_HEIGHT, MAP_HEIGHT_RST);
    write_reg(CFG_SPHERE_RADIUS, SPHERE_RADIUS_RST);
    random_samples(400, MAP_WIDTH_RST, MAP_HEIGHT_RST);
    drain();

    send_idle_pct = 81;
    write_reg(CFG_MAP_WIDTH, 360);
    write_reg(CFG_MAP_HEIGHT, 180);
    write_reg(CFG_SPHERE_RADIUS, 1000000);
    random_samples(300, 360, 180);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 81;
    write_reg(CFG_MAP_WIDTH, $urandom_range(65535, 1));
    write_reg(CFG_MAP_HEIGHT, $urandom_range(65535, 1));
    write_reg(CFG_SPHERE_RADIUS, $urandom_range(24'hFF_FFFF));
    random_samples(300, int'(width_reg), int'(height_reg));
    drain();

    send_idle_pct = 11;
    recv_stall_pct = 11;
    write_reg(CFG_MAP_WIDTH, 1000);
    write_reg(CFG_MAP_HEIGHT, 500);
    write_reg(CFG_SPHERE_RADIUS, 6371);
    random_samples(350, 1000, 500);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_samples(350, 1000, 500);
    drain();

    if (pending_points.size() != 0) begin
      $error("%0d items never delivered", pending_points.size());
      errors++;
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
